// ----- hdl/assert_macros.svh -----
// Assertion macros used by the arc unit datapath.
// No dependencies; defining ASSERT_OFF compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Implication checked at every rising clock edge, disabled while reset is held low.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Implication that holds even during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- hdl/mca_pkg.sv -----
// Package for the midpoint circle arc unit: constants, widths and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package mca_pkg;

    // Radius limit and cap on pixels per run
    localparam int MAX_RADIUS  = 63;
    localparam int MAX_RESULTS = 47;

    localparam int COORD_W = 6;
    localparam int CNT_W   = 6;
    localparam int DEC_W   = 10;

    typedef logic [COORD_W-1:0] coord_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // start a run with the incoming radius
        logic step;   // advance one pixel
    } mca_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;   // current pixel ends the run
    } mca_status_t;

endpackage

`default_nettype wire

// ----- hdl/midpoint_circle_arc_unit.sv -----
// Top level of the midpoint circle arc unit: controller plus datapath.
// Depends on mca_pkg, mca_ctrl and mca_datapath.
//
//  channel  | dir | tdata (low bit up)          | tlast
//  ---------+-----+-----------------------------+----------------
//  s_       | in  | radius[5:0], pad to 8       | -
//  m_       | out | x_coord[5:0], y_coord[5:0]  | last pixel of run
//
// A radius is taken, then one pixel word leaves per cycle from the walk
// register while m_tready is high, N = 1 to 46 pixels per radius
// (46 at radius 63). The next radius is taken the cycle after the last word.
// Reset clears only the state machine. m_tready low holds the current word
// and the walk; s_tready is low while a run is in progress.
`default_nettype none

module midpoint_circle_arc_unit
    import mca_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [5:0] radius
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [5:0] x_coord, [11:6] y_coord
    output logic             m_tlast
);

    mca_cmd_t    cmd;
    mca_status_t status;
    coord_t      x_coord;
    coord_t      y_coord;

    mca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mca_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .radius   (s_tdata[COORD_W-1:0]),
        .cmd      (cmd),
        .x_coord  (x_coord),
        .y_coord  (y_coord),
        .status   (status)
    );

    // Output word packing
    assign m_tdata = {4'b0, y_coord, x_coord};
    assign m_tlast = status.last;

endmodule

`default_nettype wire

// ----- hdl/mca_ctrl.sv -----
// Controller for the arc unit: idle/run state machine and the handshakes.
// Depends on mca_pkg.
`default_nettype none

module mca_ctrl
    import mca_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    input  wire mca_status_t status,
    output mca_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Handshake outputs follow the state
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_RUN);

    assign cmd.load = s_tvalid && s_tready;
    assign cmd.step = m_tvalid && m_tready && !status.last;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (m_tready && status.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mca_datapath.sv -----
// Datapath for the arc unit: pixel position, decision value and run count.
// Depends on mca_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mca_datapath
    import mca_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire coord_t  radius,
    input  wire mca_cmd_t cmd,
    output coord_t       x_coord,
    output coord_t       y_coord,
    output mca_status_t  status
);

    coord_t                    x_reg, x_next;
    coord_t                    y_reg, y_next;
    logic signed [DEC_W-1:0]   dec_reg, dec_next;
    logic [CNT_W-1:0]          count_reg, count_next;

    coord_t                    r_sat;
    logic signed [COORD_W:0]   diff;
    logic signed [DEC_W-1:0]   inc_e;
    logic signed [DEC_W-1:0]   inc_se;

    // Saturate the radius
    assign r_sat = ({1'b0, radius} > (COORD_W+1)'(MAX_RADIUS))
                 ? COORD_W'(MAX_RADIUS) : radius;

    // Decision increments: 2x+3 going east, 2(x-y)+5 going southeast
    assign diff   = $signed({1'b0, x_reg}) - $signed({1'b0, y_reg});
    assign inc_e  = $signed(DEC_W'({x_reg, 1'b0})) + DEC_W'(3);
    assign inc_se = $signed(DEC_W'($signed({diff, 1'b0}))) + DEC_W'(5);

    // Run ends once x reaches y or the pixel cap is hit
    assign status.last = !(y_reg > x_reg) || (count_reg >= CNT_W'(MAX_RESULTS));

    always_comb begin
        x_next     = x_reg;
        y_next     = y_reg;
        dec_next   = dec_reg;
        count_next = count_reg;
        if (cmd.load) begin
            x_next     = '0;
            y_next     = r_sat;
            dec_next   = DEC_W'(1) - $signed(DEC_W'(r_sat));
            count_next = CNT_W'(1);
        end else if (cmd.step) begin
            x_next     = x_reg + COORD_W'(1);
            count_next = count_reg + CNT_W'(1);
            if (dec_reg < 0) begin
                dec_next = dec_reg + inc_e;
            end else begin
                dec_next = dec_reg + inc_se;
                y_next   = y_reg - COORD_W'(1);
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        dec_reg   <= dec_next;
        count_reg <= count_next;
    end

    assign x_coord = x_reg;
    assign y_coord = y_reg;

    `ASSERT_CLK(a_step_x, aclk, aresetn, cmd.step |=> x_reg == $past(x_reg) + COORD_W'(1))
    `ASSERT_CLK(a_step_y, aclk, aresetn, cmd.step |=> ($past(y_reg) - y_reg) <= COORD_W'(1))
    `ASSERT_CLK(a_load, aclk, aresetn, cmd.load |=> (x_reg == '0) && (count_reg == CNT_W'(1)))
    `ASSERT_ALWAYS(a_excl, aclk, !(cmd.load && cmd.step))

endmodule

`default_nettype wire
